### rtl/core/atcs_pkg.sv
// Package for the box-against-tilemap collision step: constants, field
// layouts of the stream items, controller commands and datapath status.
// No dependencies; every other file of the block but atcs_ram uses it by scoped names.

package atcs_pkg;

    // Map geometry and fixed-point format.
    localparam int MAP_COLS    = 64;
    localparam int MAP_ROWS    = 64;
    localparam int TILE_PIXELS = 16;
    localparam int FRAC_BITS   = 8;

    localparam int MAP_W_PX = MAP_COLS * TILE_PIXELS;
    localparam int MAP_H_PX = MAP_ROWS * TILE_PIXELS;
    localparam int COL_W    = $clog2(MAP_COLS);
    localparam int ROW_W    = $clog2(MAP_ROWS);
    // Shift that turns a Q.FRAC_BITS position into a tile index.
    localparam int TILE_SH  = $clog2(TILE_PIXELS) + FRAC_BITS;

    // Field widths.
    localparam int POS_W   = 18;
    localparam int VEL_W   = 13;
    localparam int SPEED_W = 12;
    localparam int DIM_W   = 5;
    localparam int FT_W    = 16;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 2;

    // Displacement magnitude: speed * frame time, Q.16 cut to Q.FRAC_BITS.
    localparam int MAG_SH = FT_W - FRAC_BITS;
    localparam int MAG_W  = SPEED_W + FT_W - MAG_SH;
    // Signed working width for moved and snapped positions.
    localparam int ACC_W  = ((POS_W > MAG_W) ? POS_W : MAG_W) + 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 2'd2;

    localparam logic [SPEED_W-1:0] SPEED_RESET  = 12'd200;
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 5'd16;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 5'd16;

    typedef enum logic [1:0] {
        ACT_STEP  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_PLACE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // Input payload, dir_x in the lowest bits, padded to whole bytes.
    typedef struct packed {
        logic [2:0]         pad;
        logic [POS_W-1:0]   place_y;
        logic [POS_W-1:0]   place_x;
        logic               tile_solid;
        logic [ROW_W-1:0]   tile_row;
        logic [COL_W-1:0]   tile_col;
        logic [FT_W-1:0]    frame_time;
        logic signed [1:0]  dir_y;
        logic signed [1:0]  dir_x;
    } in_data_t;

    typedef struct packed {
        action_t  action;
        in_data_t data;
    } item_t;

    // Result payload, pos_x in the lowest bits.
    typedef struct packed {
        logic                    hit_y;
        logic                    hit_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_x;
        logic [POS_W-1:0]        pos_y;
        logic [POS_W-1:0]        pos_x;
    } result_t;

    localparam int IN_DATA_W  = $bits(in_data_t);
    localparam int OUT_DATA_W = $bits(result_t);

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load_item;
        logic mul;
        logic move_x;
        logic move_y;
        logic rd_lo;
        logic rd_hi;
        logic chk_x;
        logic chk_y;
        logic wr_rd;
        logic wr_wb;
        logic place;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic write_ok;
    } status_t;

endpackage

### rtl/core/atcs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.

module atcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/atcs_ctrl.sv
// Sequencer of the collision step: walks each item through its cycles and
// owns the result valid flag. Depends on atcs_pkg.

module atcs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  atcs_pkg::status_t   status,
    output atcs_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_MOVE_X,
        S_RD_LO_X,
        S_RD_HI_X,
        S_CHK_X,
        S_MOVE_Y,
        S_RD_LO_Y,
        S_RD_HI_Y,
        S_CHK_Y,
        S_WR_RD,
        S_WR_WB,
        S_PLACE,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;
    atcs_pkg::action_t action;

    assign action   = atcs_pkg::action_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd           = '0;
        cmd.load_item = s_tvalid && s_tready;
        cmd.mul       = (state_reg == S_MUL);
        cmd.move_x    = (state_reg == S_MOVE_X);
        cmd.move_y    = (state_reg == S_MOVE_Y);
        cmd.rd_lo     = (state_reg == S_RD_LO_X) || (state_reg == S_RD_LO_Y);
        cmd.rd_hi     = (state_reg == S_RD_HI_X) || (state_reg == S_RD_HI_Y);
        cmd.chk_x     = (state_reg == S_CHK_X);
        cmd.chk_y     = (state_reg == S_CHK_Y);
        cmd.wr_rd     = (state_reg == S_WR_RD);
        cmd.wr_wb     = (state_reg == S_WR_WB);
        cmd.place     = (state_reg == S_PLACE);
        cmd.out_load  = (state_reg == S_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        unique case (action)
                            atcs_pkg::ACT_STEP:  state_reg <= S_MUL;
                            atcs_pkg::ACT_WRITE: state_reg <= S_WR_RD;
                            atcs_pkg::ACT_PLACE: state_reg <= S_PLACE;
                            atcs_pkg::ACT_NONE:  state_reg <= S_DONE;
                        endcase
                    end
                end
                S_MUL:     state_reg <= S_MOVE_X;
                S_MOVE_X:  state_reg <= S_RD_LO_X;
                S_RD_LO_X: state_reg <= S_RD_HI_X;
                S_RD_HI_X: state_reg <= S_CHK_X;
                S_CHK_X:   state_reg <= S_MOVE_Y;
                S_MOVE_Y:  state_reg <= S_RD_LO_Y;
                S_RD_LO_Y: state_reg <= S_RD_HI_Y;
                S_RD_HI_Y: state_reg <= S_CHK_Y;
                S_CHK_Y:   state_reg <= S_DONE;
                S_WR_RD:   state_reg <= status.write_ok ? S_WR_WB : S_DONE;
                S_WR_WB:   state_reg <= S_DONE;
                S_PLACE:   state_reg <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    // The result register is only loaded once its previous content has gone.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken result");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid_reg)
        else $error("loaded result not presented");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

endmodule

### rtl/core/atcs_dpath.sv
// Datapath of the collision step: configuration, box position, tile map
// RAM with row valid bits, move, scan, snap and result register.
// Depends on atcs_pkg and atcs_ram.

module atcs_dpath (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_we,
    input  logic [atcs_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [atcs_pkg::CFG_W-1:0]                cfg_data,
    input  atcs_pkg::item_t                           s_item,
    input  atcs_pkg::cmd_t                            cmd,
    output atcs_pkg::status_t                         status,
    output atcs_pkg::result_t                         result
);

    localparam int POS_W   = atcs_pkg::POS_W;
    localparam int ACC_W   = atcs_pkg::ACC_W;
    localparam int VEL_W   = atcs_pkg::VEL_W;
    localparam int DIM_W   = atcs_pkg::DIM_W;
    localparam int COL_W   = atcs_pkg::COL_W;
    localparam int ROW_W   = atcs_pkg::ROW_W;
    localparam int MAG_W   = atcs_pkg::MAG_W;
    localparam int FRAC    = atcs_pkg::FRAC_BITS;
    localparam int TSH     = atcs_pkg::TILE_SH;
    localparam int PROD_W  = atcs_pkg::SPEED_W + atcs_pkg::FT_W;

    // Box size as used: zero counts as one pixel, above a tile as one tile.
    function automatic logic [DIM_W-1:0] dim_px(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(atcs_pkg::TILE_PIXELS)) begin
            r = DIM_W'(atcs_pkg::TILE_PIXELS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [ACC_W-1:0] v,
                                                   input logic signed [ACC_W-1:0] hi);
        logic [POS_W-1:0] r;
        if (v[ACC_W-1]) begin
            r = '0;
        end else if (v > hi) begin
            r = POS_W'(hi);
        end else begin
            r = POS_W'(v);
        end
        return r;
    endfunction

    // Direction codes: 1 moves forward, 2 and 3 both move backward.
    function automatic logic signed [ACC_W-1:0] disp(input logic [1:0] code,
                                                     input logic [MAG_W-1:0] m);
        logic signed [ACC_W-1:0] r;
        if (code[1]) begin
            r = -signed'(ACC_W'(m));
        end else if (code[0]) begin
            r = signed'(ACC_W'(m));
        end else begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic signed [VEL_W-1:0] vel_of(
        input logic [1:0] code, input logic [atcs_pkg::SPEED_W-1:0] s);
        logic signed [VEL_W-1:0] r;
        if (code[1]) begin
            r = -signed'(VEL_W'(s));
        end else if (code[0]) begin
            r = signed'(VEL_W'(s));
        end else begin
            r = '0;
        end
        return r;
    endfunction

    logic [atcs_pkg::SPEED_W-1:0] speed_reg;
    logic [DIM_W-1:0]             width_reg;
    logic [DIM_W-1:0]             height_reg;
    atcs_pkg::item_t              item_reg;
    logic [MAG_W-1:0]             mag_reg;
    logic [POS_W-1:0]             box_x_reg;
    logic [POS_W-1:0]             box_y_reg;
    logic signed [VEL_W-1:0]      vel_x_reg;
    logic signed [VEL_W-1:0]      vel_y_reg;
    logic                         hit_x_reg;
    logic                         hit_y_reg;
    logic                         lo_c0_reg;
    logic                         lo_c1_reg;
    logic [atcs_pkg::MAP_ROWS-1:0] row_valid_reg;
    logic                         rd_valid_reg;
    atcs_pkg::result_t            result_reg;

    logic [DIM_W-1:0]             w_px;
    logic [DIM_W-1:0]             h_px;
    logic signed [ACC_W-1:0]      hi_x;
    logic signed [ACC_W-1:0]      hi_y;
    logic [PROD_W-1:0]            prod;
    logic [POS_W:0]               x_end;
    logic [POS_W:0]               y_end;
    logic [COL_W-1:0]             c0;
    logic [COL_W-1:0]             c1;
    logic [ROW_W-1:0]             r0;
    logic [ROW_W-1:0]             r1;
    logic [ROW_W-1:0]             rd_addr;
    logic [atcs_pkg::MAP_COLS-1:0] rd_data;
    logic [atcs_pkg::MAP_COLS-1:0] row_word;
    logic [atcs_pkg::MAP_COLS-1:0] wr_word;
    logic                         hi_c0;
    logic                         hi_c1;
    logic                         found;
    logic [COL_W-1:0]             col_hit;
    logic [ROW_W-1:0]             row_hit;
    logic signed [ACC_W-1:0]      moved_x;
    logic signed [ACC_W-1:0]      moved_y;
    logic signed [ACC_W-1:0]      snap_x;
    logic signed [ACC_W-1:0]      snap_y;

    assign w_px = dim_px(width_reg);
    assign h_px = dim_px(height_reg);
    assign hi_x = signed'((ACC_W'(atcs_pkg::MAP_W_PX) - ACC_W'(w_px)) << FRAC);
    assign hi_y = signed'((ACC_W'(atcs_pkg::MAP_H_PX) - ACC_W'(h_px)) << FRAC);

    assign prod = PROD_W'(speed_reg) * PROD_W'(item_reg.data.frame_time);

    assign moved_x = signed'(ACC_W'(box_x_reg))
                   + disp(item_reg.data.dir_x, mag_reg);
    assign moved_y = signed'(ACC_W'(box_y_reg))
                   + disp(item_reg.data.dir_y, mag_reg);

    // Overlapped tiles; right and bottom edges are exclusive.
    assign x_end = (POS_W+1)'(box_x_reg) + ((POS_W+1)'(w_px) << FRAC) - (POS_W+1)'(1);
    assign y_end = (POS_W+1)'(box_y_reg) + ((POS_W+1)'(h_px) << FRAC) - (POS_W+1)'(1);
    assign c0 = box_x_reg[TSH +: COL_W];
    assign c1 = x_end[TSH +: COL_W];
    assign r0 = box_y_reg[TSH +: ROW_W];
    assign r1 = y_end[TSH +: ROW_W];

    always_comb begin
        if (cmd.wr_rd) begin
            rd_addr = item_reg.data.tile_row;
        end else if (cmd.rd_lo) begin
            rd_addr = r0;
        end else if (cmd.rd_hi) begin
            rd_addr = r1;
        end else begin
            rd_addr = r0;
        end
    end

    // A row never written reads as all empty.
    assign row_word = rd_valid_reg ? rd_data : '0;

    always_comb begin
        wr_word = row_word;
        wr_word[item_reg.data.tile_col] = item_reg.data.tile_solid;
    end

    assign hi_c0 = row_word[c0];
    assign hi_c1 = row_word[c1];
    assign found = lo_c0_reg || lo_c1_reg || hi_c0 || hi_c1;

    always_comb begin
        priority if (lo_c0_reg) begin
            col_hit = c0;
        end else if (lo_c1_reg) begin
            col_hit = c1;
        end else if (hi_c0) begin
            col_hit = c0;
        end else begin
            col_hit = c1;
        end
        row_hit = (lo_c0_reg || lo_c1_reg) ? r0 : r1;
    end

    // Snap against the near edge of the tile met, by direction of travel.
    always_comb begin
        if (vel_x_reg[VEL_W-1]) begin
            snap_x = signed'((ACC_W'(col_hit) + ACC_W'(1)) << TSH);
        end else begin
            snap_x = signed'((ACC_W'(col_hit) << TSH) - (ACC_W'(w_px) << FRAC));
        end
        if (vel_y_reg[VEL_W-1]) begin
            snap_y = signed'((ACC_W'(row_hit) + ACC_W'(1)) << TSH);
        end else begin
            snap_y = signed'((ACC_W'(row_hit) << TSH) - (ACC_W'(h_px) << FRAC));
        end
    end

    assign status.write_ok =
        ((COL_W+1)'(item_reg.data.tile_col) < (COL_W+1)'(atcs_pkg::MAP_COLS)) &&
        ((ROW_W+1)'(item_reg.data.tile_row) < (ROW_W+1)'(atcs_pkg::MAP_ROWS));

    atcs_ram #(
        .WIDTH (atcs_pkg::MAP_COLS),
        .DEPTH (atcs_pkg::MAP_ROWS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (cmd.wr_wb),
        .wr_addr (item_reg.data.tile_row),
        .wr_data (wr_word),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control state: configuration, position, velocities, flags and row valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg     <= atcs_pkg::SPEED_RESET;
            width_reg     <= atcs_pkg::WIDTH_RESET;
            height_reg    <= atcs_pkg::HEIGHT_RESET;
            box_x_reg     <= '0;
            box_y_reg     <= '0;
            hit_x_reg     <= 1'b0;
            hit_y_reg     <= 1'b0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            row_valid_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    atcs_pkg::CFG_MOVE_SPEED: speed_reg  <= cfg_data;
                    atcs_pkg::CFG_BOX_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                    atcs_pkg::CFG_BOX_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.load_item) begin
                hit_x_reg <= 1'b0;
                hit_y_reg <= 1'b0;
                vel_x_reg <= '0;
                vel_y_reg <= '0;
            end

            if (cmd.move_x) begin
                box_x_reg <= clamp_pos(moved_x, hi_x);
                box_y_reg <= clamp_pos(signed'(ACC_W'(box_y_reg)), hi_y);
                vel_x_reg <= vel_of(item_reg.data.dir_x, speed_reg);
            end

            if (cmd.chk_x && found) begin
                hit_x_reg <= 1'b1;
                vel_x_reg <= '0;
                if (vel_x_reg != '0) begin
                    box_x_reg <= clamp_pos(snap_x, hi_x);
                end
            end

            if (cmd.move_y) begin
                box_y_reg <= clamp_pos(moved_y, hi_y);
                vel_y_reg <= vel_of(item_reg.data.dir_y, speed_reg);
            end

            if (cmd.chk_y && found) begin
                hit_y_reg <= 1'b1;
                vel_y_reg <= '0;
                if (vel_y_reg != '0) begin
                    box_y_reg <= clamp_pos(snap_y, hi_y);
                end
            end

            if (cmd.place) begin
                box_x_reg <= clamp_pos(signed'(ACC_W'(item_reg.data.place_x)), hi_x);
                box_y_reg <= clamp_pos(signed'(ACC_W'(item_reg.data.place_y)), hi_y);
            end

            if (cmd.wr_wb) begin
                row_valid_reg[item_reg.data.tile_row] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_item;
        end
        if (cmd.mul) begin
            mag_reg <= prod[atcs_pkg::MAG_SH +: MAG_W];
        end
        if (cmd.rd_hi) begin
            lo_c0_reg <= hi_c0;
            lo_c1_reg <= hi_c1;
        end
        rd_valid_reg <= row_valid_reg[rd_addr];
        if (cmd.out_load) begin
            result_reg.pos_x <= box_x_reg;
            result_reg.pos_y <= box_y_reg;
            result_reg.vel_x <= vel_x_reg;
            result_reg.vel_y <= vel_y_reg;
            result_reg.hit_x <= hit_x_reg;
            result_reg.hit_y <= hit_y_reg;
        end
    end

    assign result = result_reg;

    a_hit_x_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_x_reg |-> (vel_x_reg == '0))
        else $error("X hit with nonzero X velocity");

    a_hit_y_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_y_reg |-> (vel_y_reg == '0))
        else $error("Y hit with nonzero Y velocity");

    a_snap_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.chk_x |=> (signed'(ACC_W'(box_x_reg)) <= hi_x))
        else $error("box left the map after the X pass");

    a_row_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_wb |=> row_valid_reg[$past(item_reg.data.tile_row)])
        else $error("written row not marked valid");

endmodule

### rtl/core/aabb_tile_collision_step_top.sv
// Top level of the box-against-tilemap collision step: stream ports,
// configuration port, sequencer and datapath.
// Depends on atcs_pkg, atcs_ram, atcs_ctrl and atcs_dpath.
//
//   Channel   Ports                          Direction  Carries
//   --------  -----------------------------  ---------  ---------------------------
//   input     s_tvalid s_tready s_tdata      in         one item per transfer
//             s_tuser                                   (step, tile write, place)
//   result    m_tvalid m_tready m_tdata      out        one result per item
//   config    cfg_we cfg_index cfg_data      in         register write, no handshake
//
// Sequence: a step item passes through acceptance, one multiply, then per
// axis a move, two tile-row reads of the map RAM and a check, and a last
// state that loads the result register; a tile write reads the row and
// writes it back, and a place sets the position. The result register is
// loaded as the block returns to idle, where the next item can be
// transferred. The single read port of the map RAM, used twice per axis
// pass, sets the length of a step.
// Reset (aresetn, synchronous, active low) clears the position, restores the
// register defaults and marks every map row as empty through one valid bit
// per row, so no clearing pass is needed and items are taken at once.
// Stalls: the result sits in an output register; the next item is accepted
// while it waits, and that item's result is held back until it is taken.

module aabb_tile_collision_step_top (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // From bit 0: dir_x[1:0], dir_y[3:2], frame_time[19:4], tile_col[25:20],
    // tile_row[31:26], tile_solid[32], place_x[50:33], place_y[68:51], zeros.
    input  logic [atcs_pkg::IN_DATA_W-1:0]      s_tdata,
    // action[1:0].
    input  logic [1:0]                          s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // From bit 0: pos_x[17:0], pos_y[35:18], vel_x[48:36], vel_y[61:49],
    // hit_x[62], hit_y[63].
    output logic [atcs_pkg::OUT_DATA_W-1:0]     m_tdata,

    input  logic                                cfg_we,
    input  logic [atcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [atcs_pkg::CFG_W-1:0]          cfg_data
);

    atcs_pkg::item_t   s_item;
    atcs_pkg::cmd_t    cmd;
    atcs_pkg::status_t status;
    atcs_pkg::result_t result;

    // The action travels in tuser; every other input field is in tdata.
    assign s_item.action = atcs_pkg::action_t'(s_tuser);
    assign s_item.data   = atcs_pkg::in_data_t'(s_tdata);

    // The sequencer owns both handshakes and issues one command per cycle.
    atcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the box, the map and the result register.
    atcs_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_item    (s_item),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    assign m_tdata = result;

endmodule

### tb/sv/atcs_step_checker.sv
// Checker for the box-against-tilemap collision step: watches the input, result
// and configuration ports, predicts every result and compares it field by field.
// Depends on atcs_pkg for field widths, payload layouts, actions and register indexes.

module atcs_step_checker
    import atcs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    mismatch_count,
    output int                    pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE_PX_Q = 1 << FRAC_BITS;
    localparam int TILE_Q   = TILE_PIXELS * ONE_PX_Q;

    logic [SPEED_W-1:0] speed_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    int                 box_x_q;
    int                 box_y_q;
    bit                 solid_map [MAP_COLS*MAP_ROWS];
    result_t            expected_q [$];

    // A size of zero behaves as one pixel, anything above a tile as one tile.
    function automatic int size_px(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > TILE_PIXELS) return TILE_PIXELS;
        return int'(v);
    endfunction

    function automatic int clamp_q(int v, int map_px, int box_px);
        int hi_q;
        hi_q = (map_px - box_px) * ONE_PX_Q;
        if (v < 0) return 0;
        if (v > hi_q) return hi_q;
        return v;
    endfunction

    function automatic int dir_value(logic [1:0] code);
        case (code)
            2'b00:   return 0;
            2'b01:   return 1;
            default: return -1;
        endcase
    endfunction

    function automatic bit tile_is_solid(int col, int row);
        if (col < 0 || row < 0 || col >= MAP_COLS || row >= MAP_ROWS) return 1'b1;
        return solid_map[row * MAP_COLS + col];
    endfunction

    // Rows from the top, columns from the left; right and bottom edges are exclusive.
    function automatic bit first_solid(int w_px, int h_px, output int col, output int row);
        int c0, c1, r0, r1;
        c0  = box_x_q / TILE_Q;
        c1  = (box_x_q + w_px * ONE_PX_Q - 1) / TILE_Q;
        r0  = box_y_q / TILE_Q;
        r1  = (box_y_q + h_px * ONE_PX_Q - 1) / TILE_Q;
        col = 0;
        row = 0;
        for (int r = r0; r <= r1; r++) begin
            for (int c = c0; c <= c1; c++) begin
                if (tile_is_solid(c, r)) begin
                    col = c;
                    row = r;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one item to the shadow state and returns the result it must produce.
    function automatic result_t predict_result(action_t act, in_data_t d);
        result_t r;
        int      w_px, h_px, dx, dy, vx, vy, mag, col, row;
        bit      hx, hy;
        w_px = size_px(width_reg);
        h_px = size_px(height_reg);
        vx   = 0;
        vy   = 0;
        hx   = 1'b0;
        hy   = 1'b0;
        case (act)
            ACT_STEP: begin
                dx  = dir_value(d.dir_x);
                dy  = dir_value(d.dir_y);
                mag = (int'(speed_reg) * int'(d.frame_time)) >> MAG_SH;

                vx      = dx * int'(speed_reg);
                box_x_q = clamp_q(box_x_q + dx * mag, MAP_W_PX, w_px);
                box_y_q = clamp_q(box_y_q, MAP_H_PX, h_px);
                if (first_solid(w_px, h_px, col, row)) begin
                    hx = 1'b1;
                    if (vx > 0)
                        box_x_q = clamp_q(col * TILE_Q - w_px * ONE_PX_Q, MAP_W_PX, w_px);
                    else if (vx < 0)
                        box_x_q = clamp_q((col + 1) * TILE_Q, MAP_W_PX, w_px);
                    vx = 0;
                end

                vy      = dy * int'(speed_reg);
                box_y_q = clamp_q(box_y_q + dy * mag, MAP_H_PX, h_px);
                if (first_solid(w_px, h_px, col, row)) begin
                    hy = 1'b1;
                    if (vy > 0)
                        box_y_q = clamp_q(row * TILE_Q - h_px * ONE_PX_Q, MAP_H_PX, h_px);
                    else if (vy < 0)
                        box_y_q = clamp_q((row + 1) * TILE_Q, MAP_H_PX, h_px);
                    vy = 0;
                end
            end
            ACT_WRITE: begin
                if (int'(d.tile_col) < MAP_COLS && int'(d.tile_row) < MAP_ROWS)
                    solid_map[int'(d.tile_row) * MAP_COLS + int'(d.tile_col)] = d.tile_solid;
            end
            ACT_PLACE: begin
                box_x_q = clamp_q(int'(d.place_x), MAP_W_PX, w_px);
                box_y_q = clamp_q(int'(d.place_y), MAP_H_PX, h_px);
            end
            default: ;
        endcase
        r.pos_x = box_x_q[POS_W-1:0];
        r.pos_y = box_y_q[POS_W-1:0];
        r.vel_x = vx[VEL_W-1:0];
        r.vel_y = vy[VEL_W-1:0];
        r.hit_x = hx;
        r.hit_y = hy;
        return r;
    endfunction

    task automatic compare_field(string name, logic [POS_W-1:0] want_v,
                                 logic [POS_W-1:0] got_v);
        if (got_v !== want_v) begin
            if (mismatch_count < 10)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            speed_reg  = SPEED_RESET;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            box_x_q    = 0;
            box_y_q    = 0;
            foreach (solid_map[i]) solid_map[i] = 1'b0;
            expected_q.delete();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result 0x%0h arrived with nothing expected",
                                 $time, got);
                    mismatch_count++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("pos_x", want.pos_x, got.pos_x);
                    compare_field("pos_y", want.pos_y, got.pos_y);
                    compare_field("vel_x", POS_W'(want.vel_x), POS_W'(got.vel_x));
                    compare_field("vel_y", POS_W'(want.vel_y), POS_W'(got.vel_y));
                    compare_field("hit_x", POS_W'(want.hit_x), POS_W'(got.hit_x));
                    compare_field("hit_y", POS_W'(want.hit_y), POS_W'(got.hit_y));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MOVE_SPEED: speed_reg  = cfg_data[SPEED_W-1:0];
                    CFG_BOX_WIDTH:  width_reg  = cfg_data[DIM_W-1:0];
                    CFG_BOX_HEIGHT: height_reg = cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_result(action_t'(s_tuser), in_data_t'(s_tdata)));
        end
        pending_count = expected_q.size();
    end

endmodule

### tb/sv/tb_aabb_tile_collision_step_top.sv
// Testbench top for the box-against-tilemap collision step: clock, reset, stimulus,
// result back-pressure and the verdict. Prediction and comparison live in
// atcs_step_checker; depends on atcs_pkg and aabb_tile_collision_step_top.

module tb_aabb_tile_collision_step_top;
    timeunit 1ns;
    timeprecision 1ps;

    import atcs_pkg::*;

    localparam int PX          = 1 << FRAC_BITS;   // one pixel in Q.8
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 64;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    int mismatch_count;
    int pending_count;
    int cycle_count = 0;

    // Sender burst state and receiver stall pattern state.
    int burst_left = 1;
    int rx_mode_left = 0;
    int rx_run_left = 0;
    bit rx_free_run = 1'b0;
    bit rx_level = 1'b0;

    aabb_tile_collision_step_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    atcs_step_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog. Reaching the limit means the block has hung or lost a transfer.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side back-pressure. The receiver alternates between stretches in
    // which it is always ready and stretches of ready and stall runs of random
    // length, with the occasional long stall so that a result has to sit in the
    // output register while the next item is already being worked on.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_mode_left == 0) begin
                rx_free_run  = ($urandom_range(0, 3) == 0);
                rx_mode_left = $urandom_range(50, 300);
            end
            rx_mode_left--;
            if (rx_free_run) begin
                m_tready = 1'b1;
            end else begin
                if (rx_run_left == 0) begin
                    rx_level = ~rx_level;
                    if (rx_level)
                        rx_run_left = $urandom_range(1, 10);
                    else if ($urandom_range(0, 7) == 0)
                        rx_run_left = $urandom_range(10, 40);
                    else
                        rx_run_left = $urandom_range(1, 5);
                end
                rx_run_left--;
                m_tready = rx_level;
            end
        end
    end

    // Random content in every field, so the fields an action does not use are
    // never quiet. The pad bits stay at zero.
    function automatic in_data_t noise_data();
        logic [95:0] raw;
        in_data_t    d;
        raw   = {$urandom, $urandom, $urandom};
        d     = raw[IN_DATA_W-1:0];
        d.pad = '0;
        return d;
    endfunction

    function automatic in_data_t step_data(logic [1:0] dir_x_code, logic [1:0] dir_y_code,
                                           logic [FT_W-1:0] ft);
        in_data_t d;
        d            = noise_data();
        d.dir_x      = dir_x_code;
        d.dir_y      = dir_y_code;
        d.frame_time = ft;
        return d;
    endfunction

    function automatic in_data_t write_data(int col, int row, int solid);
        in_data_t d;
        d            = noise_data();
        d.tile_col   = col[COL_W-1:0];
        d.tile_row   = row[ROW_W-1:0];
        d.tile_solid = solid[0];
        return d;
    endfunction

    function automatic in_data_t place_data(int x_q, int y_q);
        in_data_t d;
        d         = noise_data();
        d.place_x = x_q[POS_W-1:0];
        d.place_y = y_q[POS_W-1:0];
        return d;
    endfunction

    // Box size words carry random junk above the five register bits.
    function automatic logic [CFG_W-1:0] dim_word(int px);
        logic [CFG_W-1:0] word;
        word               = CFG_W'($urandom);
        word[DIM_W-1:0]    = px[DIM_W-1:0];
        return word;
    endfunction

    // Offers one item and holds it until the transfer happens. The sender works
    // in bursts: when a burst runs out, tvalid drops for a random gap, so
    // tvalid is never lowered and raised in the same step.
    task automatic send_item(action_t act, in_data_t d);
        s_tuser  = act;
        s_tdata  = d;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(9, 25)) @(negedge aclk);
            else
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(20, 60);
            else
                burst_left = $urandom_range(1, 6);
        end
    endtask

    // Stops offering items until every expected result has been taken.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        @(negedge aclk);
        while (pending_count != 0 || m_tvalid) @(negedge aclk);
    endtask

    // Writes all three registers on consecutive cycles; only called while idle.
    task automatic write_regs(int speed, logic [CFG_W-1:0] width_word,
                              logic [CFG_W-1:0] height_word);
        cfg_we    = 1'b1;
        cfg_index = CFG_MOVE_SPEED;
        cfg_data  = speed[CFG_W-1:0];
        @(negedge aclk);
        cfg_index = CFG_BOX_WIDTH;
        cfg_data  = width_word;
        @(negedge aclk);
        cfg_index = CFG_BOX_HEIGHT;
        cfg_data  = height_word;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // Random traffic. Steps dominate; tile writes and placements mostly fall in
    // the top-left corner of the map so that the box keeps meeting solid tiles.
    // Now and then a tile anywhere, a placement anywhere in the 18-bit range or
    // an item with no action is thrown in.
    task automatic random_item();
        int pick;
        int ft;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            case ($urandom_range(0, 9))
                0:       ft = ($urandom_range(0, 1) == 1) ? 'hFFFF : 0;
                1, 2:    ft = $urandom_range(0, 'hFFFF);
                default: ft = $urandom_range(0, 'h0C00);
            endcase
            send_item(ACT_STEP, step_data(2'($urandom_range(0, 3)),
                                          2'($urandom_range(0, 3)), FT_W'(ft)));
        end else if (pick < 75) begin
            if ($urandom_range(0, 4) == 0)
                send_item(ACT_WRITE, write_data($urandom_range(0, 63), $urandom_range(0, 63),
                                                $urandom_range(0, 1)));
            else
                send_item(ACT_WRITE, write_data($urandom_range(0, 11), $urandom_range(0, 11),
                                                int'($urandom_range(0, 99) < 65)));
        end else if (pick < 93) begin
            if ($urandom_range(0, 5) == 0)
                send_item(ACT_PLACE, place_data($urandom_range(0, 'h3FFFF),
                                                $urandom_range(0, 'h3FFFF)));
            else
                send_item(ACT_PLACE, place_data($urandom_range(0, 176 * PX),
                                                $urandom_range(0, 176 * PX)));
        end else begin
            send_item(ACT_NONE, noise_data());
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_STEP;
        cfg_we    = 1'b0;
        cfg_index = CFG_MOVE_SPEED;
        cfg_data  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part, with the reset register values (200 px/s, 16 x 16 box).
        // At the origin with no movement, then pushing against the low map edges.
        send_item(ACT_STEP, step_data(2'b00, 2'b00, 16'h0000));
        send_item(ACT_STEP, step_data(2'b11, 2'b11, 16'hFFFF));
        // A placement beyond the map saturates, as does a long step to the far corner.
        send_item(ACT_PLACE, place_data('h3FFFF, 'h3FFFF));
        send_item(ACT_STEP, step_data(2'b01, 2'b01, 16'hFFFF));
        send_item(ACT_NONE, noise_data());
        // A single solid tile at column 5, row 5, covering pixels 80 to 95.
        send_item(ACT_WRITE, write_data(5, 5, 1));
        send_item(ACT_PLACE, place_data(60 * PX, 80 * PX));
        send_item(ACT_STEP, step_data(2'b01, 2'b00, 16'h0800));
        // Sitting inside the tile without moving reports hits on both axes.
        send_item(ACT_PLACE, place_data(84 * PX, 84 * PX));
        send_item(ACT_STEP, step_data(2'b00, 2'b00, 16'h1234));
        // The direction code 2'b10 moves left, like 2'b11.
        send_item(ACT_PLACE, place_data(100 * PX, 80 * PX));
        send_item(ACT_STEP, step_data(2'b10, 2'b00, 16'h0800));
        // Upwards and downwards into the tile.
        send_item(ACT_PLACE, place_data(80 * PX, 100 * PX));
        send_item(ACT_STEP, step_data(2'b00, 2'b11, 16'h0800));
        send_item(ACT_PLACE, place_data(80 * PX, 60 * PX));
        send_item(ACT_STEP, step_data(2'b00, 2'b01, 16'h0800));
        // Once the tile is cleared the same move goes through.
        send_item(ACT_WRITE, write_data(5, 5, 0));
        send_item(ACT_STEP, step_data(2'b00, 2'b01, 16'h0800));
        // Corner tiles: a box pushed against the map edge over a solid corner tile, on either side.
        send_item(ACT_WRITE, write_data(63, 63, 1));
        send_item(ACT_WRITE, write_data(0, 0, 1));
        send_item(ACT_PLACE, place_data(0, 0));
        send_item(ACT_STEP, step_data(2'b11, 2'b11, 16'h0100));
        send_item(ACT_PLACE, place_data('h3FFFF, 'h3FFFF));
        send_item(ACT_STEP, step_data(2'b01, 2'b01, 16'h0100));

        // Random part in phases. Registers change only with the block idle, and
        // the settings run from the reset values through both speed extremes,
        // the smallest box and the out-of-range sizes that are folded back.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: write_regs(200, dim_word(16), dim_word(16));
                1: write_regs(4095, dim_word(16), dim_word(16));
                2: write_regs(0, dim_word(1), dim_word(1));
                3: write_regs($urandom_range(1, 800), dim_word(0), dim_word(31));
                4: write_regs($urandom_range(1, 800), dim_word($urandom_range(1, 16)),
                              dim_word($urandom_range(1, 16)));
                5: write_regs(1, dim_word(20), dim_word(0));
                default: write_regs($urandom_range(0, 4095), dim_word($urandom_range(0, 31)),
                                    dim_word($urandom_range(0, 31)));
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_item();
                // Halfway through one phase the sender holds off until the
                // result side has caught up completely.
                if (p == 3 && i == PHASE_ITEMS / 2)
                    wait_drained();
            end
        end

        // Let every result come back, then give the block a little longer in
        // case it produces anything it should not.
        wait_drained();
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
